>>> rtl/hmcp_pkg.sv
// Shared types and constants for the hex memory command parser.
// Used by the front, queue, back and top-level modules; depends on nothing.
package hmcp_pkg;

   localparam int MAX_BYTES   = 1024;
   localparam int COUNT_W     = $clog2(MAX_BYTES + 1);
   localparam int INDEX_W     = 10;
   localparam int LENGTH_W    = 11;
   localparam int ADDR_W      = 16;
   localparam int ADDR_ACC_W  = ADDR_W + 1;
   localparam int BYTE_ACC_W  = 9;
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int ROW_BYTES   = 16;

   localparam logic [7:0] CHAR_SPACE = 8'h20;

   typedef enum logic [1:0] {
      PH_ADDR = 2'd0,
      PH_SKIP = 2'd1,
      PH_DATA = 2'd2,
      PH_DROP = 2'd3
   } phase_type;

   typedef enum logic [1:0] {
      KIND_DATA  = 2'd0,
      KIND_READ  = 2'd1,
      KIND_WRITE = 2'd2,
      KIND_ERROR = 2'd3
   } kind_type;

   typedef enum logic [2:0] {
      ERR_NONE      = 3'd0,
      ERR_BAD_ADDR  = 3'd1,
      ERR_BAD_CHAR  = 3'd2,
      ERR_BAD_VALUE = 3'd3,
      ERR_OVERFLOW  = 3'd4
   } error_type;

   // Everything one character produces: an optional data byte, then an
   // optional closing result for the line.
   typedef struct packed {
      logic                  has_byte;
      logic [7:0]            data_byte;
      logic [INDEX_W-1:0]    byte_index;
      logic                  has_final;
      kind_type              kind;
      logic [ADDR_W-1:0]     address;
      logic [LENGTH_W-1:0]   length;
      error_type             error_code;
   } entry_type;

endpackage

>>> rtl/hmcp_front.sv
// Front end of the parser: accepts characters, keeps the line state and
// builds one queue entry per character that produces results. Uses hmcp_pkg.
module hmcp_front
   import hmcp_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_character,
   input  logic       req_line_end,
   input  logic       queue_full,
   output logic       push_en,
   output entry_type  push_entry
);

   phase_type              phase_ff, phase_in, phase_step;
   logic [ADDR_ACC_W-1:0]  addr_ff, addr_in, addr_step;
   logic                   too_big_ff, too_big_in, too_big_step;
   logic [BYTE_ACC_W-1:0]  bacc_ff, bacc_in, bacc_new;
   logic                   has_digit_ff, has_digit_in, has_digit_new;
   logic [COUNT_W-1:0]     count_ff, count_in, count_step;
   error_type              perr_ff, perr_in, perr_step;

   logic       accept;
   logic       hex_ok;
   logic [3:0] hex_d;
   logic       is_space;
   logic       enter_data;
   logic       addr_fail;
   logic       bad_char;
   logic       closes;
   logic       bad_value;
   logic       overflow;
   logic       emit;
   logic       fail;
   error_type  fail_code;

   assign req_stall = queue_full;
   assign accept    = req_valid && !queue_full;
   assign is_space  = (req_character == CHAR_SPACE);

   always_comb begin
      hex_ok = 1'b1;
      hex_d  = 4'd0;
      if (req_character inside {[8'h30:8'h39]}) begin
         hex_d = req_character[3:0];
      end else if (req_character inside {[8'h41:8'h46], [8'h61:8'h66]}) begin
         hex_d = req_character[3:0] + 4'd9;
      end else begin
         hex_ok = 1'b0;
      end
   end

   // A character goes to the data path when it ends the address with
   // something other than a space, follows the skipped spaces, or is data.
   assign enter_data = (phase_ff == PH_ADDR && !hex_ok && !too_big_ff && !is_space) ||
                       (phase_ff == PH_SKIP && !is_space) ||
                       (phase_ff == PH_DATA);
   assign addr_fail  = (phase_ff == PH_ADDR) && !hex_ok && too_big_ff;
   assign bad_char   = enter_data && !hex_ok && !is_space;

   always_comb begin
      bacc_new = bacc_ff;
      if (hex_ok) begin
         if (bacc_ff[BYTE_ACC_W-1:4] != '0) begin
            bacc_new = BYTE_ACC_W'(9'h100);
         end else begin
            bacc_new = {1'b0, bacc_ff[3:0], hex_d};
         end
      end
   end

   assign has_digit_new = hex_ok || has_digit_ff;
   assign closes    = enter_data && !bad_char && (is_space || req_line_end) && has_digit_new;
   assign bad_value = closes && bacc_new[BYTE_ACC_W-1];
   assign overflow  = closes && !bacc_new[BYTE_ACC_W-1] &&
                      (count_ff >= COUNT_W'(MAX_BYTES));
   assign emit      = closes && !bacc_new[BYTE_ACC_W-1] &&
                      (count_ff < COUNT_W'(MAX_BYTES));
   assign fail      = addr_fail || bad_char || bad_value || overflow;

   always_comb begin
      if (addr_fail) begin
         fail_code = ERR_BAD_ADDR;
      end else if (bad_char) begin
         fail_code = ERR_BAD_CHAR;
      end else if (bad_value) begin
         fail_code = ERR_BAD_VALUE;
      end else begin
         fail_code = ERR_OVERFLOW;
      end
   end

   // Phase after this character, before the end-of-line return to the start.
   always_comb begin
      phase_step = phase_ff;
      if (fail) begin
         phase_step = PH_DROP;
      end else begin
         case (phase_ff)
            PH_ADDR: begin
               if (hex_ok) begin
                  phase_step = PH_ADDR;
               end else if (is_space) begin
                  phase_step = PH_SKIP;
               end else begin
                  phase_step = PH_DATA;
               end
            end
            PH_SKIP: phase_step = is_space ? PH_SKIP : PH_DATA;
            PH_DATA: phase_step = PH_DATA;
            PH_DROP: phase_step = PH_DROP;
            default: phase_step = PH_DROP;
         endcase
      end
      phase_in = phase_ff;
      if (accept) begin
         phase_in = req_line_end ? PH_ADDR : phase_step;
      end
   end

   // Accumulators, counters and the queue entry.
   always_comb begin
      addr_step    = addr_ff;
      too_big_step = too_big_ff;
      if (phase_ff == PH_ADDR && hex_ok) begin
         if (addr_ff[ADDR_ACC_W-1:12] != '0) begin
            addr_step    = ADDR_ACC_W'(17'h10000);
            too_big_step = 1'b1;
         end else begin
            addr_step = {1'b0, addr_ff[11:0], hex_d};
         end
      end
      count_step = count_ff + COUNT_W'(emit);
      perr_step  = fail ? fail_code : perr_ff;

      push_entry            = '0;
      push_entry.has_byte   = emit;
      push_entry.data_byte  = bacc_new[7:0];
      push_entry.byte_index = count_ff[INDEX_W-1:0];
      push_entry.has_final  = req_line_end;
      push_entry.kind       = KIND_READ;
      push_entry.error_code = ERR_NONE;
      if (phase_step == PH_DROP) begin
         push_entry.kind       = KIND_ERROR;
         push_entry.error_code = perr_step;
      end else if (phase_step == PH_DATA) begin
         push_entry.kind    = KIND_WRITE;
         push_entry.address = addr_step[ADDR_W-1:0];
         push_entry.length  = LENGTH_W'(count_step);
      end else if (too_big_step) begin
         push_entry.kind       = KIND_ERROR;
         push_entry.error_code = ERR_BAD_ADDR;
      end else begin
         push_entry.address = addr_step[ADDR_W-1:0];
         push_entry.length  = LENGTH_W'(ROW_BYTES) - {{(LENGTH_W-4){1'b0}}, addr_step[3:0]};
      end
      push_en = accept && (emit || req_line_end);

      addr_in      = addr_ff;
      too_big_in   = too_big_ff;
      bacc_in      = bacc_ff;
      has_digit_in = has_digit_ff;
      count_in     = count_ff;
      perr_in      = perr_ff;
      if (accept) begin
         if (req_line_end) begin
            addr_in      = '0;
            too_big_in   = 1'b0;
            bacc_in      = '0;
            has_digit_in = 1'b0;
            count_in     = '0;
            perr_in      = ERR_NONE;
         end else begin
            addr_in    = addr_step;
            too_big_in = too_big_step;
            count_in   = count_step;
            perr_in    = perr_step;
            if (enter_data && !bad_char) begin
               if (closes) begin
                  bacc_in      = '0;
                  has_digit_in = 1'b0;
               end else begin
                  bacc_in      = bacc_new;
                  has_digit_in = has_digit_new;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_ADDR;
         addr_ff      <= '0;
         too_big_ff   <= 1'b0;
         bacc_ff      <= '0;
         has_digit_ff <= 1'b0;
         count_ff     <= '0;
         perr_ff      <= ERR_NONE;
      end else begin
         phase_ff     <= phase_in;
         addr_ff      <= addr_in;
         too_big_ff   <= too_big_in;
         bacc_ff      <= bacc_in;
         has_digit_ff <= has_digit_in;
         count_ff     <= count_in;
         perr_ff      <= perr_in;
      end
   end

endmodule

>>> rtl/hmcp_queue.sv
// Short queue of parsed entries between the front and back of the parser.
// Uses entry_type and the depth constants from hmcp_pkg.
module hmcp_queue
   import hmcp_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      push_en,
   input  entry_type push_entry,
   output logic      full,
   input  logic      pop_en,
   output logic      not_empty,
   output entry_type head
);

   entry_type           entries_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QPTR_W:0]     count_ff, count_in;

   assign full      = (count_ff == (QPTR_W+1)'(QUEUE_DEPTH));
   assign not_empty = (count_ff != '0);
   assign head      = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push_en ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop_en  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + (QPTR_W+1)'(push_en) - (QPTR_W+1)'(pop_en);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_en) begin
         entries_ff[wr_ptr_ff] <= push_entry;
      end
   end

   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      !(push_en && full))
      else $error("queue pushed while full");

   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      !(pop_en && !not_empty))
      else $error("queue popped while empty");

   a_count_track: assert property (@(posedge clock) disable iff (reset)
      (push_en && !pop_en) |=> (count_ff == $past(count_ff) + 1'b1))
      else $error("queue count did not follow a push");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= (QPTR_W+1)'(QUEUE_DEPTH))
      else $error("queue count above depth");

endmodule

>>> rtl/hmcp_back.sv
// Back end of the parser: takes entries from the queue and delivers the data
// byte and closing results one at a time from registers. Uses hmcp_pkg.
module hmcp_back
   import hmcp_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                not_empty,
   input  entry_type           head,
   output logic                pop_en,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [1:0]          rsp_kind,
   output logic [ADDR_W-1:0]   rsp_address,
   output logic [7:0]          rsp_data_byte,
   output logic [INDEX_W-1:0]  rsp_byte_index,
   output logic [LENGTH_W-1:0] rsp_length,
   output logic [2:0]          rsp_error_code,
   output logic                rsp_final_res
);

   entry_type cur_ff, cur_in;
   logic      valid_ff, valid_in;
   logic      byte_sent_ff, byte_sent_in;
   logic      show_byte;
   logic      taken;
   logic      done;

   assign show_byte = cur_ff.has_byte && !byte_sent_ff;
   assign taken     = valid_ff && !rsp_stall;
   // An entry is finished once its last pending result is taken.
   assign done      = taken && !(show_byte && cur_ff.has_final);
   assign pop_en    = (!valid_ff || done) && not_empty;

   always_comb begin
      cur_in       = cur_ff;
      valid_in     = valid_ff;
      byte_sent_in = byte_sent_ff;
      if (pop_en) begin
         cur_in       = head;
         valid_in     = 1'b1;
         byte_sent_in = 1'b0;
      end else if (done) begin
         valid_in = 1'b0;
      end else if (taken) begin
         byte_sent_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= 1'b0;
         byte_sent_ff <= 1'b0;
      end else begin
         valid_ff     <= valid_in;
         byte_sent_ff <= byte_sent_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
   end

   always_comb begin
      rsp_valid = valid_ff;
      if (show_byte) begin
         rsp_kind       = KIND_DATA;
         rsp_address    = '0;
         rsp_data_byte  = cur_ff.data_byte;
         rsp_byte_index = cur_ff.byte_index;
         rsp_length     = '0;
         rsp_error_code = ERR_NONE;
         rsp_final_res  = 1'b0;
      end else begin
         rsp_kind       = cur_ff.kind;
         rsp_address    = cur_ff.address;
         rsp_data_byte  = '0;
         rsp_byte_index = '0;
         rsp_length     = cur_ff.length;
         rsp_error_code = cur_ff.error_code;
         rsp_final_res  = 1'b1;
      end
   end

endmodule

>>> rtl/hex_memory_command_parser_core.sv
// Top level of the hex memory command parser: front end, entry queue, back end.
// Depends on hmcp_pkg, hmcp_front, hmcp_queue and hmcp_back.
//
//   Channel  Dir  Handshake            Payload
//   req      in   req_valid/req_stall  req_character, req_line_end
//   rsp      out  rsp_valid/rsp_stall  kind, address, data_byte, byte_index,
//                                      length, error_code, final_res
//
// One character is accepted per cycle while the four-entry queue has room.
// A character that produces results appears on rsp once it has passed the queue and the
// back-end entry register; a data byte and the closing result are delivered one at a time.
// Reset is synchronous and returns the parser to the start of a line.
// A stall on rsp backs up into the queue and then stalls req.
module hex_memory_command_parser_core
   import hmcp_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [7:0]          req_character,
   input  logic                req_line_end,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [1:0]          rsp_kind,
   output logic [ADDR_W-1:0]   rsp_address,
   output logic [7:0]          rsp_data_byte,
   output logic [INDEX_W-1:0]  rsp_byte_index,
   output logic [LENGTH_W-1:0] rsp_length,
   output logic [2:0]          rsp_error_code,
   output logic                rsp_final_res
);

   logic      queue_full;
   logic      push_en;
   entry_type push_entry;
   logic      pop_en;
   logic      not_empty;
   entry_type head;

   hmcp_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_character (req_character),
      .req_line_end  (req_line_end),
      .queue_full    (queue_full),
      .push_en       (push_en),
      .push_entry    (push_entry)
   );

   hmcp_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_en    (push_en),
      .push_entry (push_entry),
      .full       (queue_full),
      .pop_en     (pop_en),
      .not_empty  (not_empty),
      .head       (head)
   );

   hmcp_back u_back (
      .clock          (clock),
      .reset          (reset),
      .not_empty      (not_empty),
      .head           (head),
      .pop_en         (pop_en),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_kind       (rsp_kind),
      .rsp_address    (rsp_address),
      .rsp_data_byte  (rsp_data_byte),
      .rsp_byte_index (rsp_byte_index),
      .rsp_length     (rsp_length),
      .rsp_error_code (rsp_error_code),
      .rsp_final_res  (rsp_final_res)
   );

endmodule

>>> tb/hex_memory_command_parser_core_test.sv
// Self-checking testbench for hex_memory_command_parser_core: directed lines, then random
// monitor lines under four idle and stall patterns, all checked against a line parser model.
// Depends on hmcp_pkg and the RTL of the parser core.
module hex_memory_command_parser_core_test;
   import hmcp_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      kind_type            kind;
      logic [ADDR_W-1:0]   address;
      logic [7:0]          data_byte;
      logic [INDEX_W-1:0]  byte_index;
      logic [LENGTH_W-1:0] length;
      error_type           error_code;
      logic                final_res;
   } parser_result_type;

   typedef struct packed {
      logic [7:0]        ch;
      logic              last;
      logic              typed;
      parser_result_type closing;
   } char_row_type;

   localparam parser_result_type NO_RESULT = '0;
   localparam int NUM_DIRECTED = 24;
   localparam int ITEMS_PER_PHASE = 430;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   logic [7:0]          req_character = 8'h00;
   logic                req_line_end = 1'b0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   logic [1:0]          rsp_kind;
   logic [ADDR_W-1:0]   rsp_address;
   logic [7:0]          rsp_data_byte;
   logic [INDEX_W-1:0]  rsp_byte_index;
   logic [LENGTH_W-1:0] rsp_length;
   logic [2:0]          rsp_error_code;
   logic                rsp_final_res;

   hex_memory_command_parser_core dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_character  (req_character),
      .req_line_end   (req_line_end),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_kind       (rsp_kind),
      .rsp_address    (rsp_address),
      .rsp_data_byte  (rsp_data_byte),
      .rsp_byte_index (rsp_byte_index),
      .rsp_length     (rsp_length),
      .rsp_error_code (rsp_error_code),
      .rsp_final_res  (rsp_final_res)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Model state of the line being parsed.
   phase_type      ln_phase;
   logic [16:0]    ln_addr;
   logic           ln_addr_big;
   logic [8:0]     ln_byte;
   logic           ln_has_digit;
   logic [10:0]    ln_count;
   error_type      ln_error;

   parser_result_type expected_q[$];
   char_row_type      char_q[$];
   char_row_type      cur_row;
   int             idle_pct = 0;
   int             stall_pct = 0;
   int             failures = 0;
   int             queued_chars = 0;
   int             accepted_chars = 0;
   int             checked_results = 0;
   int             closed_lines = 0;
   int             error_lines = 0;

   function automatic parser_result_type read_res(logic [ADDR_W-1:0] a,
                                                  logic [LENGTH_W-1:0] len);
      parser_result_type r;
      r = NO_RESULT;
      r.kind = KIND_READ;
      r.address = a;
      r.length = len;
      r.final_res = 1'b1;
      return r;
   endfunction

   function automatic parser_result_type error_res(error_type code);
      parser_result_type r;
      r = NO_RESULT;
      r.kind = KIND_ERROR;
      r.error_code = code;
      r.final_res = 1'b1;
      return r;
   endfunction

   // Closing results are typed in where they are plain to see; the rest come from the model.
   char_row_type directed_rows [NUM_DIRECTED] = '{
      '{"5",   1'b1, 1'b1, read_res(16'h0005, 11'd11)},
      '{" ",   1'b1, 1'b1, read_res(16'h0000, 11'd16)},
      '{"F",   1'b0, 1'b0, NO_RESULT},
      '{"f",   1'b0, 1'b0, NO_RESULT},
      '{"F",   1'b0, 1'b0, NO_RESULT},
      '{"f",   1'b1, 1'b1, read_res(16'hFFFF, 11'd1)},
      '{"1",   1'b0, 1'b0, NO_RESULT},
      '{"0",   1'b0, 1'b0, NO_RESULT},
      '{"0",   1'b0, 1'b0, NO_RESULT},
      '{"0",   1'b0, 1'b0, NO_RESULT},
      '{"0",   1'b0, 1'b0, NO_RESULT},
      '{"Z",   1'b1, 1'b1, error_res(ERR_BAD_ADDR)},
      '{"G",   1'b1, 1'b1, error_res(ERR_BAD_CHAR)},
      '{"a",   1'b0, 1'b0, NO_RESULT},
      '{" ",   1'b0, 1'b0, NO_RESULT},
      '{"f",   1'b0, 1'b0, NO_RESULT},
      '{"F",   1'b1, 1'b0, NO_RESULT},
      '{"0",   1'b0, 1'b0, NO_RESULT},
      '{" ",   1'b0, 1'b0, NO_RESULT},
      '{"1",   1'b0, 1'b0, NO_RESULT},
      '{"0",   1'b0, 1'b0, NO_RESULT},
      '{"0",   1'b1, 1'b1, error_res(ERR_BAD_VALUE)},
      '{"9",   1'b0, 1'b0, NO_RESULT},
      '{8'hFF, 1'b1, 1'b1, error_res(ERR_BAD_CHAR)}
   };

   function automatic int hex_nibble(logic [7:0] c);
      if (c >= "0" && c <= "9") return int'(c - 8'h30);
      if (c >= "A" && c <= "F") return int'(c - 8'h37);
      if (c >= "a" && c <= "f") return int'(c - 8'h57);
      return -1;
   endfunction

   function automatic logic [7:0] hex_char(int v);
      if (v < 10) return 8'h30 + 8'(v);
      if ($urandom_range(1) == 0) return 8'h37 + 8'(v);
      return 8'h57 + 8'(v);
   endfunction

   task automatic clear_line();
      ln_phase = PH_ADDR;
      ln_addr = '0;
      ln_addr_big = 1'b0;
      ln_byte = '0;
      ln_has_digit = 1'b0;
      ln_count = '0;
      ln_error = ERR_NONE;
   endtask

   task automatic add_result(kind_type k, logic [ADDR_W-1:0] a, logic [7:0] db,
                             logic [INDEX_W-1:0] idx, logic [LENGTH_W-1:0] len,
                             error_type e, logic fin);
      parser_result_type r;
      r.kind = k;
      r.address = a;
      r.data_byte = db;
      r.byte_index = idx;
      r.length = len;
      r.error_code = e;
      r.final_res = fin;
      expected_q.push_back(r);
   endtask

   task automatic abort_line(error_type code);
      ln_error = code;
      ln_phase = PH_DROP;
   endtask

   task automatic parse_data_char(logic [7:0] c, logic last);
      int d;
      int acc;
      d = hex_nibble(c);
      if (d >= 0) begin
         acc = int'(ln_byte) * 16 + d;
         if (acc > 'hFF) acc = 'h100;
         ln_byte = acc[8:0];
         ln_has_digit = 1'b1;
      end else if (c != CHAR_SPACE) begin
         abort_line(ERR_BAD_CHAR);
         return;
      end
      if ((c == CHAR_SPACE || last) && ln_has_digit) begin
         if (ln_byte > 9'h0FF) begin
            abort_line(ERR_BAD_VALUE);
         end else if (ln_count >= MAX_BYTES) begin
            abort_line(ERR_OVERFLOW);
         end else begin
            add_result(KIND_DATA, '0, ln_byte[7:0], ln_count[INDEX_W-1:0], '0, ERR_NONE, 1'b0);
            ln_count = ln_count + 11'd1;
         end
         ln_byte = '0;
         ln_has_digit = 1'b0;
      end
   endtask

   task automatic parse_char(logic [7:0] c, logic last);
      int d;
      int acc;
      d = hex_nibble(c);
      case (ln_phase)
         PH_ADDR: begin
            if (d >= 0) begin
               acc = int'(ln_addr) * 16 + d;
               // The address saturates rather than wrapping.
               if (acc > 'hFFFF) begin
                  ln_addr_big = 1'b1;
                  acc = 'h10000;
               end
               ln_addr = acc[16:0];
            end else if (ln_addr_big) begin
               abort_line(ERR_BAD_ADDR);
            end else if (c == CHAR_SPACE) begin
               ln_phase = PH_SKIP;
            end else begin
               ln_phase = PH_DATA;
               parse_data_char(c, last);
            end
         end
         PH_SKIP: begin
            if (c != CHAR_SPACE) begin
               ln_phase = PH_DATA;
               parse_data_char(c, last);
            end
         end
         PH_DATA: begin
            parse_data_char(c, last);
         end
         default: begin
         end
      endcase
      if (last) begin
         if (ln_phase == PH_DROP) begin
            add_result(KIND_ERROR, '0, '0, '0, '0, ln_error, 1'b1);
         end else if (ln_phase == PH_DATA) begin
            add_result(KIND_WRITE, ln_addr[15:0], '0, '0, ln_count, ERR_NONE, 1'b1);
         end else if (ln_addr_big) begin
            add_result(KIND_ERROR, '0, '0, '0, '0, ERR_BAD_ADDR, 1'b1);
         end else begin
            add_result(KIND_READ, ln_addr[15:0], '0, '0, 11'd16 - {7'd0, ln_addr[3:0]},
                       ERR_NONE, 1'b1);
         end
         clear_line();
      end
   endtask

   // Builds one random line; a nonzero forced_bytes gives a clean write of that many bytes.
   task automatic gen_line(int forced_bytes);
      logic [7:0]   text[$];
      char_row_type row;
      int           shape;
      int           n_addr;
      int           n_bytes;
      int           n_dig;
      int           pos;
      shape = (forced_bytes > 0) ? 50 : $urandom_range(99);
      if (shape >= 90) begin
         repeat ($urandom_range(1, 6)) text.push_back(8'($urandom_range(255)));
      end else begin
         n_addr = ($urandom_range(9) == 0) ? $urandom_range(5, 6) : $urandom_range(0, 4);
         if (forced_bytes > 0) n_addr = 4;
         repeat (n_addr) text.push_back(hex_char($urandom_range(15)));
         if (shape < 20) begin
            repeat ($urandom_range(0, 2)) text.push_back(CHAR_SPACE);
         end else begin
            n_bytes = (forced_bytes > 0) ? forced_bytes : $urandom_range(1, 8);
            for (int b = 0; b < n_bytes; b++) begin
               repeat ((forced_bytes > 0) ? 1 : $urandom_range(1, 2)) text.push_back(CHAR_SPACE);
               n_dig = (forced_bytes == 0 && $urandom_range(19) == 0) ? 3 : $urandom_range(1, 2);
               // Half of the three-digit bytes carry a leading zero and still fit.
               if (n_dig == 3 && $urandom_range(1) == 1) begin
                  text.push_back("0");
                  n_dig = 2;
               end
               repeat (n_dig) text.push_back(hex_char($urandom_range(15)));
            end
            if (forced_bytes == 0 && $urandom_range(4) == 0) text.push_back(CHAR_SPACE);
            if (shape >= 75) begin
               pos = $urandom_range(text.size() - 1);
               text[pos] = 8'($urandom_range(255));
            end
         end
      end
      if (text.size() == 0) text.push_back(CHAR_SPACE);
      foreach (text[i]) begin
         row.ch = text[i];
         row.last = (i == text.size() - 1);
         row.typed = 1'b0;
         row.closing = NO_RESULT;
         char_q.push_back(row);
         queued_chars++;
      end
   endtask

   task automatic check_field(string name, logic [15:0] want, logic [15:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
         failures++;
      end
   endtask

   always @(posedge clock) begin : drive_and_check
      parser_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         checked_results++;
         if (expected_q.size() == 0) begin
            $display("%0t: result kind %0d with nothing expected, expected none, got one",
                     $time, rsp_kind);
            failures++;
         end else begin
            want = expected_q.pop_front();
            check_field("kind", 16'(want.kind), 16'(rsp_kind));
            check_field("address", want.address, rsp_address);
            check_field("data_byte", 16'(want.data_byte), 16'(rsp_data_byte));
            check_field("byte_index", 16'(want.byte_index), 16'(rsp_byte_index));
            check_field("length", 16'(want.length), 16'(rsp_length));
            check_field("error_code", 16'(want.error_code), 16'(rsp_error_code));
            check_field("final_res", 16'(want.final_res), 16'(rsp_final_res));
            if (want.final_res) closed_lines++;
            if (want.kind == KIND_ERROR) error_lines++;
         end
      end

      rsp_stall <= ($urandom_range(99) < stall_pct);

      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || !req_stall) begin
         // The request on the bus was taken at this edge, so its results are due now.
         if (req_valid) begin
            accepted_chars++;
            parse_char(cur_row.ch, cur_row.last);
            if (cur_row.typed) begin
               void'(expected_q.pop_back());
               expected_q.push_back(cur_row.closing);
            end
         end
         if (char_q.size() != 0 && $urandom_range(99) >= idle_pct) begin
            cur_row = char_q.pop_front();
            req_valid <= 1'b1;
            req_character <= cur_row.ch;
            req_line_end <= cur_row.last;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   initial begin
      int idle_tab[4];
      int stall_tab[4];
      int target;
      idle_tab = '{0, 87, 0, 13};
      stall_tab = '{0, 0, 87, 13};
      clear_line();
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      for (int p = 0; p < 4; p++) begin
         @(negedge clock);
         idle_pct = idle_tab[p];
         stall_pct = stall_tab[p];
         if (p == 0) begin
            for (int i = 0; i < NUM_DIRECTED; i++) char_q.push_back(directed_rows[i]);
         end
         target = queued_chars + ITEMS_PER_PHASE;
         while (queued_chars < target) gen_line(0);
         while (char_q.size() != 0 || req_valid) @(posedge clock);
      end

      while (expected_q.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);

      $display("Sent %0d characters under four idle patterns; checked %0d results",
               accepted_chars, checked_results);
      $display("closing %0d lines, %0d of them errors.", closed_lines, error_lines);
      if (failures == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("Timeout with %0d results still expected", expected_q.size());
      $display("Some tests failed");
      $finish;
   end

endmodule

>>> filelist.f
rtl/hmcp_pkg.sv
rtl/hmcp_front.sv
rtl/hmcp_queue.sv
rtl/hmcp_back.sv
rtl/hex_memory_command_parser_core.sv
tb/hex_memory_command_parser_core_test.sv
